// ===== rtl/lcd4_pkg.sv =====
`timescale 1ns / 1ps
package lcd4_pkg;

  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned WAIT_W    = 16;
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_SETUP  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INIT   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR  = CFG_IDX_W'(3);

  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_SEND   = 3'd1,
    OP_CURSOR = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_HOME   = 3'd4,
    OP_MODE   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    JOB_INIT  = 2'd0,
    JOB_BYTE  = 2'd1,
    JOB_CLEAR = 2'd2,
    JOB_HOME  = 2'd3
  } job_kind_e;

  // Fixed command list walked by init; clear starts at 0x01, home at 0x02.
  localparam logic [2:0] SEQ_FIRST = 3'd0;
  localparam logic [2:0] SEQ_CLEAR = 3'd3;
  localparam logic [2:0] SEQ_HOME  = 3'd4;
  localparam logic [2:0] SEQ_LAST  = 3'd4;

  localparam logic [3:0] PRE_LAST  = 4'd10;
  localparam logic [3:0] BYTE_LAST = 4'd8;

  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

  typedef struct packed {
    logic [2:0] op;
    logic       is_data;
    logic [7:0] data_byte;
    logic [1:0] row;
    logic [5:0] col;
    logic [1:0] display_mode;
  } in_req_t;

  typedef struct packed {
    logic              rs_pin;
    logic              en_pin;
    logic [3:0]        data_nibble;
    logic [WAIT_W-1:0] wait_units;
    logic              last;
  } out_req_t;

  typedef struct packed {
    job_kind_e  kind;
    logic       rs;
    logic [7:0] cmd;
  } job_t;

  typedef struct packed {
    logic [WAIT_W-1:0] setup_wait;
    logic [WAIT_W-1:0] warmup_wait;
    logic [WAIT_W-1:0] init_wait;
    logic [WAIT_W-1:0] clear_wait;
  } cfg_t;

  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] b;
    case (row)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h14;
      default: b = 8'h54;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] mode_cmd(input logic [1:0] mode);
    logic [7:0] c;
    case (mode)
      2'd0:    c = 8'h08;
      2'd1:    c = 8'h0C;
      2'd2:    c = 8'h0E;
      default: c = 8'h0F;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] seq_cmd(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h28;
      3'd1:    c = 8'h0C;
      3'd2:    c = 8'h06;
      3'd3:    c = 8'h01;
      default: c = 8'h02;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/lcd4_front.sv =====
`timescale 1ns / 1ps
module lcd4_front import lcd4_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  in_req_t in_req_i,
  output logic    job_valid_o,
  input  logic    job_ready_i,
  output job_t    job_o
);

  logic valid_q, valid_d;
  job_t job_q, job_d;
  logic usable;
  logic take;

  // Classify the request into a job for the back end
  always_comb begin
    usable = 1'b1;
    job_d  = job_q;
    case (in_req_i.op)
      OP_INIT: begin
        job_d.kind = JOB_INIT;
        job_d.rs   = 1'b0;
        job_d.cmd  = 8'h00;
      end
      OP_SEND: begin
        job_d.kind = JOB_BYTE;
        job_d.rs   = in_req_i.is_data;
        job_d.cmd  = in_req_i.data_byte;
      end
      OP_CURSOR: begin
        job_d.kind = JOB_BYTE;
        job_d.rs   = 1'b0;
        job_d.cmd  = CMD_SET_DDRAM | row_base(in_req_i.row) | {2'b00, in_req_i.col};
      end
      OP_CLEAR: begin
        job_d.kind = JOB_CLEAR;
        job_d.rs   = 1'b0;
        job_d.cmd  = 8'h00;
      end
      OP_HOME: begin
        job_d.kind = JOB_HOME;
        job_d.rs   = 1'b0;
        job_d.cmd  = 8'h00;
      end
      OP_MODE: begin
        job_d.kind = JOB_BYTE;
        job_d.rs   = 1'b0;
        job_d.cmd  = mode_cmd(in_req_i.display_mode);
      end
      default: usable = 1'b0; // unused codes: accept and drop
    endcase
  end

  assign in_ready_o = !valid_q || job_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take && usable) begin
      valid_d = 1'b1;
    end else if (job_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && usable) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = valid_q;
  assign job_o       = job_q;

endmodule

// ===== rtl/lcd4_queue.sv =====
`timescale 1ns / 1ps
module lcd4_queue import lcd4_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_job_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = count_q != QCNT_W'(QDEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? QPTR_W'((wr_ptr_q + 1'b1) % QDEPTH) : wr_ptr_q;
    rd_ptr_d = pop  ? QPTR_W'((rd_ptr_q + 1'b1) % QDEPTH) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== rtl/lcd4_back.sv =====
`timescale 1ns / 1ps
module lcd4_back import lcd4_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     job_valid_i,
  output logic     job_ready_o,
  input  job_t     job_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_req_t out_req_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PRE  = 3'b010,
    ST_BYTE = 3'b100
  } state_e;

  state_e     state_q, state_d;
  job_t       job_q;
  logic [3:0] step_q, step_d;
  logic [2:0] idx_q, idx_d;
  logic       rs_q, rs_d;
  logic       en_q, en_d;
  logic [3:0] nib_q, nib_d;
  logic       out_valid_q, out_valid_d;
  out_req_t   out_q, out_d;

  logic              emit;
  logic              load;
  logic              is_last;
  logic [WAIT_W-1:0] wait_val;
  logic [7:0]        cur_cmd;
  logic              cur_rs;

  assign emit        = (state_q != ST_IDLE) && (!out_valid_q || out_ready_i);
  assign job_ready_o = state_q == ST_IDLE;
  assign load        = job_valid_i && job_ready_o;

  assign cur_cmd = (job_q.kind == JOB_BYTE) ? job_q.cmd : seq_cmd(idx_q);
  assign cur_rs  = (job_q.kind == JOB_BYTE) ? job_q.rs  : 1'b0;
  assign is_last = (state_q == ST_BYTE) && (step_q == BYTE_LAST) &&
                   ((job_q.kind == JOB_BYTE) || (idx_q == SEQ_LAST));

  // Pin levels after the current write
  always_comb begin
    rs_d     = rs_q;
    en_d     = en_q;
    nib_d    = nib_q;
    wait_val = '0;
    case (state_q)
      ST_PRE: begin
        case (step_q)
          4'd0: nib_d = 4'h0;
          4'd1: begin
            rs_d     = 1'b0;
            en_d     = 1'b0;
            wait_val = cfg_i.warmup_wait;
          end
          4'd2: begin
            rs_d     = 1'b0;
            wait_val = cfg_i.init_wait;
          end
          4'd3, 4'd7:        nib_d = 4'h2;
          4'd5, 4'd9:        en_d  = 1'b1;
          default:           en_d  = 1'b0;
        endcase
      end
      ST_BYTE: begin
        case (step_q)
          4'd0: begin
            rs_d     = cur_rs;
            wait_val = cfg_i.setup_wait;
          end
          4'd1:       nib_d = cur_cmd[7:4];
          4'd5:       nib_d = cur_cmd[3:0];
          4'd3, 4'd7: en_d  = 1'b1;
          default:    en_d  = 1'b0;
        endcase
        if (is_last && (job_q.kind != JOB_BYTE)) begin
          wait_val = cfg_i.clear_wait;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (load) begin
          step_d = '0;
          case (job_i.kind)
            JOB_INIT: begin
              state_d = ST_PRE;
              idx_d   = SEQ_FIRST;
            end
            JOB_CLEAR: begin
              state_d = ST_BYTE;
              idx_d   = SEQ_CLEAR;
            end
            JOB_HOME: begin
              state_d = ST_BYTE;
              idx_d   = SEQ_HOME;
            end
            default: begin
              state_d = ST_BYTE;
              idx_d   = SEQ_LAST;
            end
          endcase
        end
      end
      ST_PRE: begin
        if (emit) begin
          if (step_q == PRE_LAST) begin
            state_d = ST_BYTE;
            step_d  = '0;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      ST_BYTE: begin
        if (emit) begin
          if (is_last) begin
            state_d = ST_IDLE;
          end else if (step_q == BYTE_LAST) begin
            step_d = '0;
            idx_d  = idx_q + 1'b1;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d       = 1'b1;
      out_d.rs_pin      = rs_d;
      out_d.en_pin      = en_d;
      out_d.data_nibble = nib_d;
      out_d.wait_units  = wait_val;
      out_d.last        = is_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      idx_q       <= '0;
      rs_q        <= 1'b0;
      en_q        <= 1'b0;
      nib_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (emit) begin
        rs_q  <= rs_d;
        en_q  <= en_d;
        nib_q <= nib_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (load) begin
      job_q <= job_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  a_pre_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PRE |-> step_q <= PRE_LAST)
    else $error("preamble step out of range");

  a_byte_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BYTE |-> step_q <= BYTE_LAST)
    else $error("byte step out of range");

  a_pre_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PRE |-> job_q.kind == JOB_INIT)
    else $error("preamble outside init");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && is_last |=> state_q == ST_IDLE)
    else $error("sequencer busy after final write");

  a_seq_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BYTE |-> idx_q <= SEQ_LAST)
    else $error("command list index out of range");

endmodule

// ===== rtl/char_lcd_4bit_command_sequencer.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_ready_o  in_req_i  (in_req_t, one op)
// out       output     out_valid_o/out_ready_i out_req_o (out_req_t, one pin write)
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// The back-end sequencer produces one pin write per cycle while out_ready_i
// does not stall it; an op is loaded only while the back end is idle, then
// issues its pin writes in turn. Unused op codes are taken and dropped.
// Reset drives the held pin levels low and the wait registers to their defaults.
// A stalled output holds the sequencer; the front stage and a two-entry
// job queue keep taking ops until both are full.
module char_lcd_4bit_command_sequencer import lcd4_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_req_t              in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_req_t             out_req_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WAIT_W-1:0]    cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  logic f_valid, f_ready;
  job_t f_job;
  logic q_valid, q_ready;
  job_t q_job;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SETUP:  cfg_d.setup_wait  = cfg_data_i;
        REG_WARMUP: cfg_d.warmup_wait = cfg_data_i;
        REG_INIT:   cfg_d.init_wait   = cfg_data_i;
        REG_CLEAR:  cfg_d.clear_wait  = cfg_data_i;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setup_wait  <= WAIT_W'(400);
      cfg_q.warmup_wait <= WAIT_W'(10000);
      cfg_q.init_wait   <= WAIT_W'(15000);
      cfg_q.clear_wait  <= WAIT_W'(30000);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lcd4_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready),
    .job_o       (f_job)
  );

  lcd4_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_job_i   (f_job),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_job_o    (q_job)
  );

  lcd4_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule
